/* src/assert_macros.svh */
// Assertion macros shared by the codec RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define LIC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define LIC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define LIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/lic_pkg.sv */
// Package for the logical immediate codec: transfer payload types, mode codes
// and small mask helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lic_pkg;

  localparam logic MODE_EXPAND = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [12:0] encoding_in;
    logic [63:0] value_in;
  } lic_req_t;

  typedef struct packed {
    logic [63:0] value_out;
    logic [12:0] encoding_out;
    logic        valid_res;
  } lic_rsp_t;

  // Low-bit mask of an element of 2**len bits, as an index mask (len 0..6).
  function automatic logic [5:0] lic_levels(input logic [2:0] len);
    logic [6:0] t;
    t = (7'd1 << len) - 7'd1;
    return t[5:0];
  endfunction

  // Bit i set when i lies inside the first element of 2**len bits.
  function automatic logic [63:0] lic_emask(input logic [2:0] len);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 64; i++) begin
      m[i] = ((7'(i) >> len) == 7'd0);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* src/logical_immediate_codec.sv */
// Logical (bitmask) immediate codec: expands a 13-bit N:immr:imms encoding to
// its 64-bit pattern, or finds the encoding of a 64-bit value.
// Depends on lic_pkg and assert_macros.svh.
//
// Usage:
//   Request channel req_valid/req_ready/req carries mode, encoding_in and
//   value_in; a transfer happens on a clock edge with valid and ready high.
//   Response channel rsp_valid/rsp_ready/rsp carries value_out, encoding_out
//   and valid_res, one response per request, in request order.
//   A request passes three register stages: field decode / period
//   search, pattern build / run locate, rotate / encoding assembly, the
//   last one being the output reg.
//   Throughput: one request per cycle, sustained, with no bubbles, while
//   rsp_ready stays high.
//   Each stage holds its own valid bit; a stage advances when it is empty
//   or the stage after it advances, so a stalled receiver fills the pipe
//   and req_ready drops only when all three stages hold a request.
//   Reset (rst, synchronous, active high) empties all stages; data
//   registers are not cleared.
//   Invalid encodings and unencodable values (zero, all ones, anything
//   that is not a replicated rotated run of ones) return zeros with
//   valid_res low.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module logical_immediate_codec (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  input  wire lic_pkg::lic_req_t req,
  output logic             rsp_valid,
  input  wire              rsp_ready,
  output lic_pkg::lic_rsp_t rsp
);
  import lic_pkg::*;

  // Stage 1: decoded fields and encode-side preprocessing.
  typedef struct packed {
    logic            mode;
    logic            dec_ok;
    logic [5:0]      dec_levels;
    logic [5:0]      dec_s;
    logic [5:0]      dec_r;
    logic [2:0]      enc_len;
    logic [63:0]     enc_starts;
    logic [7:0][3:0] enc_bytecnt;
  } s1_t;

  // Stage 2: unrotated pattern and located run.
  typedef struct packed {
    logic        mode;
    logic        dec_ok;
    logic [5:0]  dec_r;
    logic [63:0] dec_pattern;
    logic [2:0]  enc_len;
    logic        enc_one;
    logic [5:0]  enc_pos;
    logic [6:0]  enc_pc;
  } s2_t;

  logic     v1, v2, v3;
  logic     rdy1, rdy2, rdy3;
  s1_t      s1, s1_next;
  s2_t      s2, s2_next;
  lic_rsp_t rsp_next;

  // Ready chain: a stage takes new data when empty or when it drains.
  assign rdy3      = !v3 || rsp_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign req_ready = rdy1;
  assign rsp_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= req_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1  <= s1_next;
    if (rdy2) s2  <= s2_next;
    if (rdy3) rsp <= rsp_next;
  end

  // Stage 1 logic.
  always_comb begin
    logic [5:0]  imms;
    logic [5:0]  immr;
    logic [5:0]  inv;
    logic [2:0]  dlen;
    logic [63:0] v;
    logic [63:0] rotv;

    imms = req.encoding_in[5:0];
    immr = req.encoding_in[11:6];
    inv  = ~imms;
    v    = req.value_in;

    s1_next      = '0;
    s1_next.mode = req.mode;

    // Element size: N forces 64 bits, else highest clear bit of imms[5:1].
    dlen           = 3'd0;
    s1_next.dec_ok = 1'b0;
    if (req.encoding_in[12]) begin
      dlen           = 3'd6;
      s1_next.dec_ok = 1'b1;
    end else begin
      for (int k = 1; k <= 5; k++) begin
        if (inv[k]) begin
          dlen           = 3'(k);
          s1_next.dec_ok = 1'b1;
        end
      end
      // Drop non-canonical immr with bits at or above the element size.
      if ((immr >> dlen) != 6'd0) s1_next.dec_ok = 1'b0;
    end
    s1_next.dec_levels = lic_levels(dlen);
    // An all-ones run inside the element is reserved.
    if ((imms & s1_next.dec_levels) == s1_next.dec_levels) s1_next.dec_ok = 1'b0;
    s1_next.dec_s = imms & s1_next.dec_levels;
    s1_next.dec_r = immr & s1_next.dec_levels;

    // Smallest period of the value among 2..32, else 64.
    s1_next.enc_len = 3'd6;
    for (int k = 5; k >= 1; k--) begin
      rotv = (v >> (1 << k)) | (v << (64 - (1 << k)));
      if (rotv == v) s1_next.enc_len = 3'(k);
    end

    // Run starts: a one whose lower neighbor (circularly) is zero.
    s1_next.enc_starts = v & ~{v[62:0], v[63]};

    for (int b = 0; b < 8; b++) begin
      s1_next.enc_bytecnt[b] = '0;
      for (int i = 0; i < 8; i++) begin
        s1_next.enc_bytecnt[b] = s1_next.enc_bytecnt[b] + 4'(v[8*b+i]);
      end
    end
  end

  // Stage 2 logic.
  always_comb begin
    logic [63:0] sm;

    s2_next         = '0;
    s2_next.mode    = s1.mode;
    s2_next.dec_ok  = s1.dec_ok;
    s2_next.dec_r   = s1.dec_r;
    s2_next.enc_len = s1.enc_len;

    // Replicated run of s+1 ones per element, not yet rotated.
    for (int i = 0; i < 64; i++) begin
      s2_next.dec_pattern[i] = ((6'(i) & s1.dec_levels) <= s1.dec_s);
    end

    // Exactly one run start inside the first element means one run.
    sm = s1.enc_starts & lic_emask(s1.enc_len);
    s2_next.enc_one = (sm != 64'd0) && ((sm & (sm - 64'd1)) == 64'd0);
    s2_next.enc_pos = '0;
    for (int i = 0; i < 64; i++) begin
      if (sm[i]) s2_next.enc_pos = s2_next.enc_pos | 6'(i);
    end

    s2_next.enc_pc = '0;
    for (int b = 0; b < 8; b++) begin
      s2_next.enc_pc = s2_next.enc_pc + 7'(s1.enc_bytecnt[b]);
    end
  end

  // Stage 3 logic: rotate, assemble the encoding, select by mode.
  always_comb begin
    logic [127:0] dbl;
    logic [5:0]   elevels;
    logic [6:0]   cnt;
    logic [5:0]   cm1;
    logic [5:0]   rot_e;
    logic [5:0]   imms_e;
    logic         n_e;

    dbl     = {s2.dec_pattern, s2.dec_pattern} >> s2.dec_r;
    elevels = lic_levels(s2.enc_len);
    // Total ones over 64 bits is the run length times the element count.
    cnt     = s2.enc_pc >> (3'd6 - s2.enc_len);
    cm1     = 6'(cnt - 7'd1);
    rot_e   = (6'd0 - s2.enc_pos) & elevels;
    n_e     = (s2.enc_len == 3'd6);
    imms_e  = n_e ? cm1 : (~{elevels[4:0], 1'b1} | cm1);

    rsp_next = '0;
    if (s2.mode == MODE_EXPAND) begin
      rsp_next.valid_res = s2.dec_ok;
      if (s2.dec_ok) rsp_next.value_out = dbl[63:0];
    end else begin
      rsp_next.valid_res = s2.enc_one;
      if (s2.enc_one) rsp_next.encoding_out = {n_e, rot_e, imms_e};
    end
  end

  `LIC_ASSERT_IMPLY(a_full_when_blocked, !req_ready, v1 && v2 && v3,
                    "req_ready low with a free stage")
  `LIC_ASSERT_NEXT(a_take_fills_s1, req_valid && req_ready, v1,
                   "accepted request lost at stage 1")
  `LIC_ASSERT_IMPLY(a_one_side_only, rsp_valid,
                    (rsp.value_out == 64'd0) || (rsp.encoding_out == 13'd0),
                    "value and encoding both nonzero")
  `LIC_ASSERT_IMPLY(a_invalid_is_zero, rsp_valid && !rsp.valid_res,
                    (rsp.value_out == 64'd0) && (rsp.encoding_out == 13'd0),
                    "invalid response carries data")

endmodule

`default_nettype wire

/* sim/logical_immediate_codec_tb.sv */
// Self-checking testbench for logical_immediate_codec: expands and encodes
// bitmask immediates through the valid/ready channels and checks every response.
// Depends on lic_pkg and the logical_immediate_codec RTL.
`timescale 1ns / 1ps

module logical_immediate_codec_tb;
  import lic_pkg::*;

  // Tracks the responses still owed by the block and checks each one
  // against a local model of the bitmask immediate rules.
  class lic_scoreboard;
    lic_rsp_t    owed_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function logic [63:0] low_ones(int unsigned count);
      return (count >= 64) ? '1 : ((64'd1 << count) - 64'd1);
    endfunction

    // A run of 'ones' set bits, rotated right by 'rot' inside an element of
    // 'esize' bits, then copied across the whole 64-bit word.
    function logic [63:0] run_pattern(int unsigned esize, int unsigned ones,
                                      int unsigned rot);
      logic [63:0] x;
      int unsigned w;
      x = low_ones(ones);
      if (rot != 0) x = ((x >> rot) | (x << (esize - rot))) & low_ones(esize);
      for (w = esize; w < 64; w = w * 2) x = x | (x << w);
      return x;
    endfunction

    function lic_rsp_t expand_encoding(logic [12:0] enc);
      lic_rsp_t    res;
      logic        n;
      logic [5:0]  immr;
      logic [5:0]  imms;
      logic [5:0]  levels;
      int unsigned len;
      res  = '0;
      n    = enc[12];
      immr = enc[11:6];
      imms = enc[5:0];
      len  = 0;
      // Element size: N set means 64 bits, otherwise the top clear bit of imms.
      if (n) len = 6;
      else begin
        for (int i = 5; i > 0; i--) begin
          if (!imms[i] && len == 0) len = i;
        end
      end
      if (len == 0) return res;
      // Rotation bits above the element size make the encoding illegal.
      if (!n && (immr >> len) != 6'd0) return res;
      levels = 6'((32'd1 << len) - 1);
      if ((imms & levels) == levels) return res;
      res.value_out = run_pattern(32'd1 << len, (imms & levels) + 1, immr & levels);
      res.valid_res = 1'b1;
      return res;
    endfunction

    function lic_rsp_t encode_value(logic [63:0] v);
      lic_rsp_t    res;
      logic [63:0] x;
      int unsigned esize;
      int unsigned ones;
      int unsigned rot;
      int unsigned imms;
      bit          found;
      res = '0;
      if (v == '0 || v == '1) return res;
      // Find the smallest period of the word.
      esize = 2;
      while (esize < 64 && ((v >> esize) | (v << (64 - esize))) != v) esize = esize * 2;
      x    = v & low_ones(esize);
      ones = $countones(x);
      if (ones == 0 || ones >= esize) return res;
      found = 1'b0;
      rot   = 0;
      for (int r = 0; r < esize; r++) begin
        if (!found && run_pattern(esize, ones, r) == v) begin
          found = 1'b1;
          rot   = r;
        end
      end
      if (!found) return res;
      if (esize == 64) imms = ones - 1;
      else imms = ((~(2 * esize - 1)) & 32'h3f) | (ones - 1);
      res.encoding_out = {(esize == 64), 6'(rot), 6'(imms)};
      res.valid_res    = 1'b1;
      return res;
    endfunction

    function void note_request(lic_req_t item);
      if (item.mode == MODE_EXPAND) owed_q.push_back(expand_encoding(item.encoding_in));
      else owed_q.push_back(encode_value(item.value_in));
    endfunction

    function void check_response(lic_rsp_t got);
      lic_rsp_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected response: value %h enc %h valid %b",
                   got.value_out, got.encoding_out, got.valid_res);
        return;
      end
      want = owed_q.pop_front();
      if (got.value_out !== want.value_out || got.encoding_out !== want.encoding_out ||
          got.valid_res !== want.valid_res) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected value %h enc %h valid %b, got value %h enc %h valid %b",
                   want.value_out, want.encoding_out, want.valid_res,
                   got.value_out, got.encoding_out, got.valid_res);
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  lic_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  lic_rsp_t rsp;

  lic_scoreboard book;

  // Idle limits for each side; the stimulus block changes them per stretch.
  int unsigned src_gap_max  = 14;
  int unsigned sink_wait_max = 14;
  // Set by the stimulus to ask the sink for one long hold-off.
  bit          hold_req = 1'b0;

  logical_immediate_codec uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the pipe hangs.
  initial begin
    #2_000_000;
    $display("** logical_immediate_codec: FAILED **");
    $finish;
  end

  // Build a request; fill the field the chosen mode ignores with noise.
  function automatic lic_req_t make_req(logic mode, logic [12:0] enc, logic [63:0] val);
    lic_req_t r;
    r.mode        = mode;
    r.encoding_in = (mode == MODE_EXPAND) ? enc : 13'($urandom);
    r.value_in    = (mode == MODE_ENCODE) ? val : {$urandom, $urandom};
    return r;
  endfunction

  // Random request, biased toward legal encodings and encodable values.
  function automatic lic_req_t random_request();
    int unsigned pick;
    int unsigned len;
    int unsigned esize;
    int unsigned imms;
    int unsigned flip;
    logic [63:0] v;
    pick = $urandom_range(9, 0);
    if ($urandom_range(1, 0) == 0) begin
      if (pick < 5) begin
        // Canonical encoding: size prefix in imms, immr inside the element.
        len   = $urandom_range(6, 1);
        esize = 32'd1 << len;
        if (len == 6) imms = $urandom_range(62, 0);
        else imms = ((~(2 * esize - 1)) & 32'h3f) | $urandom_range(esize - 2, 0);
        return make_req(MODE_EXPAND,
                        {(len == 6), 6'($urandom_range(esize - 1, 0)), 6'(imms)}, '0);
      end
      return make_req(MODE_EXPAND, 13'($urandom), '0);
    end
    if (pick < 8) begin
      len   = $urandom_range(6, 1);
      esize = 32'd1 << len;
      v = book.run_pattern(esize, $urandom_range(esize - 1, 1), $urandom_range(esize - 1, 0));
      // Flip one bit now and then to land just outside the encodable set.
      if (pick >= 6) begin
        flip    = $urandom_range(63, 0);
        v[flip] = ~v[flip];
      end
      return make_req(MODE_ENCODE, '0, v);
    end
    if (pick == 8) return make_req(MODE_ENCODE, '0, {$urandom, $urandom});
    case ($urandom_range(3, 0))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1 << $urandom_range(63, 0);
      default: v = ~(64'd1 << $urandom_range(63, 0));
    endcase
    return make_req(MODE_ENCODE, '0, v);
  endfunction

  // Offer one request after 'gap' idle cycles and hold it until the transfer.
  task automatic send_req(lic_req_t item, int unsigned gap);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    book.note_request(item);
  endtask

  // Wait until the block has returned everything it owes.
  task automatic drain();
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Response sink: draw a stall per response, take the long hold-off on request.
  initial begin : response_sink
    int unsigned pause;
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        pause    = 60;
        hold_req = 1'b0;
      end else pause = $urandom_range(sink_wait_max, 0);
      if (pause > 0) begin
        rsp_ready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      book.check_response(rsp);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    lic_req_t directed[$];
    int unsigned seg;
    book = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Expand: smallest run in 32-bit elements, all bits set, full-width runs.
    directed.push_back(make_req(MODE_EXPAND, 13'h0000, '0));
    directed.push_back(make_req(MODE_EXPAND, 13'h1fff, '0));
    directed.push_back(make_req(MODE_EXPAND, {1'b1, 6'd0, 6'd0}, '0));
    directed.push_back(make_req(MODE_EXPAND, {1'b1, 6'd63, 6'd62}, '0));
    directed.push_back(make_req(MODE_EXPAND, {1'b0, 6'd1, 6'h3c}, '0));
    directed.push_back(make_req(MODE_EXPAND, {1'b0, 6'd15, 6'h27}, '0));
    // No size bit in imms.
    directed.push_back(make_req(MODE_EXPAND, {1'b0, 6'd0, 6'h3e}, '0));
    directed.push_back(make_req(MODE_EXPAND, {1'b0, 6'd63, 6'h3f}, '0));
    // Rotation bits above the element size.
    directed.push_back(make_req(MODE_EXPAND, {1'b0, 6'd2, 6'h3c}, '0));
    directed.push_back(make_req(MODE_EXPAND, {1'b0, 6'h20, 6'h00}, '0));
    // Run that fills the whole element.
    directed.push_back(make_req(MODE_EXPAND, {1'b0, 6'd0, 6'h1f}, '0));
    directed.push_back(make_req(MODE_EXPAND, {1'b0, 6'd1, 6'h3b}, '0));
    // Encode: zero and all ones, then edge runs and near misses.
    directed.push_back(make_req(MODE_ENCODE, '0, 64'h0000_0000_0000_0000));
    directed.push_back(make_req(MODE_ENCODE, '0, 64'hffff_ffff_ffff_ffff));
    directed.push_back(make_req(MODE_ENCODE, '0, 64'h5555_5555_5555_5555));
    directed.push_back(make_req(MODE_ENCODE, '0, 64'h0000_0000_0000_0001));
    directed.push_back(make_req(MODE_ENCODE, '0, 64'h8000_0000_0000_0000));
    directed.push_back(make_req(MODE_ENCODE, '0, 64'h7fff_ffff_ffff_ffff));
    directed.push_back(make_req(MODE_ENCODE, '0, 64'hffff_ffff_ffff_fffe));
    directed.push_back(make_req(MODE_ENCODE, '0, 64'h0000_0000_0000_0005));
    directed.push_back(make_req(MODE_ENCODE, '0, 64'h0000_ffff_0000_ffff));
    directed.push_back(make_req(MODE_ENCODE, '0, 64'h00ff_00ff_00ff_00fe));
    directed.push_back(make_req(MODE_ENCODE, '0, 64'hf00f_f00f_f00f_f00f));
    foreach (directed[k]) send_req(directed[k], $urandom_range(src_gap_max, 0));

    for (seg = 0; seg < 11; seg++) begin
      // Rotate through idle mixes, including stretches with no idling at all.
      case (seg % 4)
        0: begin src_gap_max = 14; sink_wait_max = 14; end
        1: begin src_gap_max = 0;  sink_wait_max = 0;  end
        2: begin src_gap_max = 0;  sink_wait_max = 14; end
        default: begin src_gap_max = 14; sink_wait_max = 0; end
      endcase
      // Stall the sink for a long stretch while the source keeps pushing.
      if (seg == 3) begin
        src_gap_max = 0;
        hold_req    = 1'b1;
      end
      // Pause the source until every owed response is back.
      if (seg == 6) begin
        @(negedge clk);
        req_valid <= 1'b0;
        drain();
      end
      repeat (100) send_req(random_request(), $urandom_range(src_gap_max, 0));
    end

    @(negedge clk);
    req_valid <= 1'b0;
    drain();
    // Watch a few more cycles for stray responses.
    repeat (10) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("** logical_immediate_codec: PASSED **");
    end else begin
      $display("** logical_immediate_codec: FAILED **");
    end
    $finish;
  end

endmodule
